// ===== hw/rtl/kps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kps_pkg
// Shared widths, keyword table and stage types of the keyword presence scanner.
// ----------------------------------------------------------------------------
package kps_pkg;

  localparam int unsigned BYTE_W              = 8;
  localparam int unsigned MASK_W              = 16;
  localparam int unsigned KW_SLOTS            = 16;
  localparam int unsigned KW_COLS             = 9;
  localparam int unsigned KW_LEN_W            = 4;
  localparam int unsigned NUM_KEYWORDS_DEF    = 16;
  localparam int unsigned MAX_KEYWORD_LEN_DEF = 9;

  // Each keyword is right-justified: its last character sits in byte 0.
  typedef logic [KW_COLS*BYTE_W-1:0] kw_text_t;

  localparam kw_text_t KW_TEXT [KW_SLOTS] = '{
    "if", "using", "namespace", "return", "int", "float", "double", "char",
    "void", "bool", "false", "true", "cout", "cin", "std", "include"
  };

  localparam logic [KW_LEN_W-1:0] KW_LEN [KW_SLOTS] = '{
    4'd2, 4'd5, 4'd9, 4'd6, 4'd3, 4'd5, 4'd6, 4'd4,
    4'd4, 4'd4, 4'd5, 4'd4, 4'd4, 4'd3, 4'd3, 4'd7
  };

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] text_byte;
    logic              end_of_text;
  } stage_t;

  typedef struct packed {
    logic              valid;
    logic [MASK_W-1:0] found_mask;
  } result_t;

endpackage

// ===== hw/rtl/kps_intf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kps_intf
// Valid/ready channels of the keyword presence scanner: text in, mask out.
// ----------------------------------------------------------------------------
interface kps_text_if;
  logic                      valid;
  logic                      ready;
  logic [kps_pkg::BYTE_W-1:0] text_byte;
  logic                      end_of_text;

  modport source (output valid, text_byte, end_of_text, input ready);
  modport sink   (input valid, text_byte, end_of_text, output ready);
endinterface

interface kps_mask_if;
  logic                      valid;
  logic                      ready;
  logic [kps_pkg::MASK_W-1:0] found_mask;

  modport source (output valid, found_mask, input ready);
  modport sink   (input valid, found_mask, output ready);
endinterface

// ===== hw/rtl/kps_input_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kps_input_stage
// Input register of the scanner; decides when the held byte is consumed.
// ----------------------------------------------------------------------------
module kps_input_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  kps_text_if.sink         text_i,
  input  logic             res_free_i,
  output kps_pkg::stage_t  stage_o,
  output logic             step_o
);

  logic                       valid_q;
  logic [kps_pkg::BYTE_W-1:0] byte_q;
  logic                       eot_q;

  // Only a last byte can wait, and only while the result register is full.
  assign step_o       = valid_q && (!eot_q || res_free_i);
  assign text_i.ready = !valid_q || step_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (text_i.ready) begin
      valid_q <= text_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (text_i.ready && text_i.valid) begin
      byte_q <= text_i.text_byte;
      eot_q  <= text_i.end_of_text;
    end
  end

  assign stage_o.valid       = valid_q;
  assign stage_o.text_byte   = byte_q;
  assign stage_o.end_of_text = eot_q;

`ifndef SYNTHESIS
  a_stall_only_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !text_i.ready |-> (valid_q && eot_q && !res_free_i))
    else $error("input stalled without a waiting last byte");
`endif

endmodule

// ===== hw/rtl/kps_matcher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kps_matcher
// Byte window, parallel keyword compare and sticky found flags.
// ----------------------------------------------------------------------------
module kps_matcher #(
  parameter int unsigned NUM_KEYWORDS    = kps_pkg::NUM_KEYWORDS_DEF,
  parameter int unsigned MAX_KEYWORD_LEN = kps_pkg::MAX_KEYWORD_LEN_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  kps_pkg::stage_t  stage_i,
  input  logic             step_i,
  output kps_pkg::result_t res_o
);

  localparam int unsigned WIN_DEPTH = MAX_KEYWORD_LEN - 1;
  localparam int unsigned CMP_LEN   = (kps_pkg::KW_COLS < MAX_KEYWORD_LEN) ?
                                      kps_pkg::KW_COLS : MAX_KEYWORD_LEN;

  logic [WIN_DEPTH-1:0][kps_pkg::BYTE_W-1:0]       window_q;
  logic [MAX_KEYWORD_LEN-1:0][kps_pkg::BYTE_W-1:0] recent;
  logic [kps_pkg::MASK_W-1:0]                      flags_q;
  logic [kps_pkg::MASK_W-1:0]                      hits;
  logic [kps_pkg::MASK_W-1:0]                      used_mask;

  // recent[0] is the current byte, recent[j] the byte j positions earlier.
  assign recent = {window_q, stage_i.text_byte};

  always_comb begin
    logic match;
    hits      = '0;
    used_mask = '0;
    for (int k = 0; k < kps_pkg::KW_SLOTS; k++) begin
      used_mask[k] = (k < NUM_KEYWORDS);
      match = (k < NUM_KEYWORDS) && (int'(kps_pkg::KW_LEN[k]) <= MAX_KEYWORD_LEN);
      for (int j = 0; j < CMP_LEN; j++) begin
        if ((j < int'(kps_pkg::KW_LEN[k])) &&
            (recent[j] != kps_pkg::KW_TEXT[k][j*kps_pkg::BYTE_W +: kps_pkg::BYTE_W])) begin
          match = 1'b0;
        end
      end
      hits[k] = match;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
      flags_q  <= '0;
    end else if (step_i) begin
      if (stage_i.end_of_text) begin
        window_q <= '0;
        flags_q  <= '0;
      end else begin
        window_q <= recent[WIN_DEPTH-1:0];
        flags_q  <= flags_q | hits;
      end
    end
  end

  assign res_o.valid      = step_i && stage_i.end_of_text;
  assign res_o.found_mask = flags_q | hits;

`ifndef SYNTHESIS
  a_clear_after_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && stage_i.end_of_text) |=> (flags_q == '0 && window_q == '0))
    else $error("window or flags not cleared after the last byte");

  a_unused_bits_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (flags_q & ~used_mask) == '0)
    else $error("flag set for a keyword that is not searched");
`endif

endmodule

// ===== hw/rtl/kps_result_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kps_result_stage
// Output register holding the found mask until the sink takes it.
// ----------------------------------------------------------------------------
module kps_result_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  kps_pkg::result_t res_i,
  output logic             res_free_o,
  kps_mask_if.source       mask_o
);

  logic                       valid_q;
  logic [kps_pkg::MASK_W-1:0] mask_q;

  assign res_free_o = !valid_q || mask_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_free_o) begin
      valid_q <= res_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_free_o && res_i.valid) begin
      mask_q <= res_i.found_mask;
    end
  end

  assign mask_o.valid      = valid_q;
  assign mask_o.found_mask = mask_q;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_i.valid |-> (!valid_q || mask_o.ready))
    else $error("new mask arrived while the held one was not taken");
`endif

endmodule

// ===== hw/rtl/keyword_presence_scanner_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyword_presence_scanner_unit
// Finds which of 16 fixed keywords occur as substrings in a byte stream.
// ----------------------------------------------------------------------------
// Text enters one byte per transfer on text_i, the last byte flagged by
// end_of_text. Every byte is compared combinationally against all keywords using
// the window of preceding bytes, so the block takes one byte per clock cycle
// whenever mask_o is not holding back a result. On the last byte it delivers
// the found mask (bit 0 = "if" ... bit 15 = "include") through an input register
// and an output register, and then starts the next text with an empty window
// and cleared flags. A last byte waits in the input register only while an
// earlier mask is still untaken.
module keyword_presence_scanner_unit #(
  parameter int unsigned NUM_KEYWORDS    = kps_pkg::NUM_KEYWORDS_DEF,
  parameter int unsigned MAX_KEYWORD_LEN = kps_pkg::MAX_KEYWORD_LEN_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  kps_text_if.sink   text_i,
  kps_mask_if.source mask_o
);

  kps_pkg::stage_t  stage;
  kps_pkg::result_t res;
  logic             step;
  logic             res_free;

  kps_input_stage u_input (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .text_i     (text_i),
    .res_free_i (res_free),
    .stage_o    (stage),
    .step_o     (step)
  );

  kps_matcher #(
    .NUM_KEYWORDS    (NUM_KEYWORDS),
    .MAX_KEYWORD_LEN (MAX_KEYWORD_LEN)
  ) u_matcher (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stage_i (stage),
    .step_i  (step),
    .res_o   (res)
  );

  kps_result_stage u_result (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_i      (res),
    .res_free_o (res_free),
    .mask_o     (mask_o)
  );

endmodule
